// ===== rtl/core/itra_pkg.sv =====
`timescale 1ns / 1ps

package itra_pkg;

  // Default magnitude width and bits retired per divide cycle
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DIV_BITS        = 8;

  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 7'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CODE  = 7'h30;
  localparam logic [CHAR_W-1:0] ALPHA_CODE = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_LOAD
  } state_t;

  // "0123456789abcdef"
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < 4'd10) begin
      code = ZERO_CODE + CHAR_W'(d);
    end else begin
      code = ALPHA_CODE + CHAR_W'(d - 4'd10);
    end
    return code;
  endfunction

  // Out-of-range radix codes are clamped into 2..16
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] eff;
    if (r < RADIX_MIN) begin
      eff = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      eff = RADIX_MAX;
    end else begin
      eff = r;
    end
    return eff;
  endfunction

endpackage

// ===== rtl/core/itra_ifs.sv =====
`timescale 1ns / 1ps

interface itra_in_if #(parameter int VW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itra_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface itra_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] radix;
  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

// ===== rtl/core/itra_div.sv =====
`timescale 1ns / 1ps

// Long-division slice: retires STEP_BITS quotient bits of a small divisor
module itra_div #(
  parameter int STEP_BITS = itra_pkg::DIV_BITS
) (
  input  logic [itra_pkg::RADIX_W-1:0] radix,
  input  logic [itra_pkg::DIGIT_W-1:0] rem_in,
  input  logic [STEP_BITS-1:0]         chunk,
  output logic [STEP_BITS-1:0]         quot,
  output logic [itra_pkg::DIGIT_W-1:0] rem_out
);
  import itra_pkg::*;

  always_comb begin
    logic [DIGIT_W:0]   t;
    logic [DIGIT_W-1:0] r;
    r    = rem_in;
    quot = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= radix) begin
        quot[i] = 1'b1;
        r       = DIGIT_W'(t - radix);
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    rem_out = r;
  end

endmodule

// ===== rtl/core/integer_to_radix_ascii.sv =====
`timescale 1ns / 1ps

// Signed integer to ASCII text in a configurable radix.
// in_if  : one beat carries a signed VALUE_WIDTH-bit value.
// out_if : one beat per character, most significant first; a leading '-'
//          for negatives, digits 0-9 then a-f, last_char set on the final one.
// cfg_if : ready whenever out of reset; one beat writes radix (0/1 act as 2,
//          17+ as 16). Write it only while the block is idle.
// Timing: the divider retires DIV_BITS quotient bits a cycle, so one digit
//   is one full pass over the padded dividend. Then each character is a
//   digit memory read (FETCH) followed by an output load (LOAD), with a
//   SIGN state ahead of the digits for a negative value. Zero skips the
//   divider. Receiver stalls hold the SIGN and LOAD states.
//   in_if.ready is high only between items.
// Reset: synchronous rst_n clears the sequencer, output valid and sets the
//   radix to 10. The digit memory is not cleared; it is always written
//   before it is read for the same item.
// Stall: the output register holds its beat while out_if.ready is low and
//   the sequencer waits on it; no character is dropped or repeated.
module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itra_in_if.sink    in_if,
  itra_out_if.source out_if,
  itra_cfg_if.sink   cfg_if
);
  import itra_pkg::*;

  localparam int NSTEP = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PW    = NSTEP * DIV_BITS;            // padded dividend width
  localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int CW    = $clog2(VALUE_WIDTH + 1);     // digit count
  localparam int IW    = $clog2(VALUE_WIDTH);         // digit memory address

  state_t state_r, state_nxt;

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] radix_eff;

  logic [PW-1:0]      work_r, work_nxt;     // dividend, becomes quotient in place
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_code_r, out_code_nxt;
  logic               out_last_r, out_last_nxt;

  // Digit memory, least significant digit at address 0
  logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [DIGIT_W-1:0] wr_data;
  logic [IW-1:0]      rd_addr;
  logic [DIGIT_W-1:0] rd_digit_r;

  logic [DIV_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]  div_rem;

  logic [VALUE_WIDTH-1:0] in_mag;
  logic                   in_neg;
  logic                   slot_free;

  assign radix_eff = clamp_radix(radix_r);
  assign in_neg    = in_if.value[VALUE_WIDTH-1];
  assign in_mag    = in_neg ? VALUE_WIDTH'(-in_if.value) : in_if.value;
  assign slot_free = !out_valid_r || out_if.ready;

  // no beat is taken while reset holds
  assign in_if.ready      = rst_n && (state_r == ST_IDLE);
  assign cfg_if.ready     = rst_n;
  assign out_if.valid     = out_valid_r;
  assign out_if.char_code = out_code_r;
  assign out_if.last_char = out_last_r;

  assign rd_addr = IW'(cnt_r - 1'b1);

  // Shared divide slice, fed the top DIV_BITS of the working dividend
  itra_div #(
    .STEP_BITS (DIV_BITS)
  ) u_div (
    .radix   (radix_eff),
    .rem_in  (rem_r),
    .chunk   (work_r[PW-1 -: DIV_BITS]),
    .quot    (div_quot),
    .rem_out (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_if.valid) begin
        radix_r <= cfg_if.radix;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[wr_addr] <= wr_data;
    end
    rd_digit_r <= digit_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = IW'(cnt_r);
    wr_data       = div_rem;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          work_nxt = PW'(in_mag);
          rem_nxt  = '0;
          step_nxt = '0;
          neg_nxt  = in_neg;
          if (in_mag == '0) begin
            // zero converts to a lone "0"
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = '0;
            cnt_nxt   = CW'(1);
            state_nxt = ST_FETCH;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        work_nxt = (work_r << DIV_BITS) | PW'(div_quot);
        rem_nxt  = div_rem;
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(NSTEP - 1)) begin
          // digit done: remainder is the digit, work holds the quotient
          wr_en    = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          rem_nxt  = '0;
          step_nxt = '0;
          if (work_nxt == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_FETCH;
          end
        end
      end

      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = MINUS_CODE;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_FETCH;
        end
      end

      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = digit_char(rd_digit_r);
          out_last_nxt  = (cnt_r == CW'(1));
          cnt_nxt       = cnt_r - 1'b1;
          state_nxt     = (cnt_r == CW'(1)) ? ST_IDLE : ST_FETCH;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import itra_pkg::*;

  // One expected output beat: an ASCII code plus the end-of-string flag
  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } char_beat_t;

  // One directed row; an empty text means "ask the predictor"
  typedef struct {
    logic [RADIX_W-1:0] radix;
    logic [31:0]        value;
    string              text;
  } conversion_case_t;

  localparam string GLYPHS       = "0123456789abcdef";
  localparam int    PHASES       = 10;
  localparam int    PHASE_ITEMS  = 15;
  localparam int    TAIL_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst_n;

  itra_in_if #(.VW(32)) in_ch ();
  itra_out_if           out_ch ();
  itra_cfg_if           cfg_ch ();

  integer_to_radix_ascii #(
    .VALUE_WIDTH(32)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Characters still owed by the block, oldest first
  char_beat_t         chars_due[$];
  conversion_case_t   conversion_cases[$];
  char_beat_t         oldest;
  logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;  // our copy of the radix register
  int                 idle_pct = 19;               // per-cycle idle odds, both sides
  int                 errors = 0;

  // 100 MHz
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: set well above the worst case of every item plus stalls; reaching it fails the run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Text the block should produce for value under radix code radix_code.
  // Out-of-range codes clamp to 2..16; the magnitude is taken as unsigned
  // so the most negative value spells 2^31.
  function automatic string spell_value(logic [31:0] value, logic [RADIX_W-1:0] radix_code);
    logic [31:0] base;
    logic [31:0] magnitude;
    string       text;
    if (radix_code < RADIX_MIN) begin
      base = 32'(RADIX_MIN);
    end else if (radix_code > RADIX_MAX) begin
      base = 32'(RADIX_MAX);
    end else begin
      base = 32'(radix_code);
    end
    magnitude = value[31] ? (~value + 32'd1) : value;
    text = "";
    // zero still yields one digit
    do begin
      text      = $sformatf("%c%s", GLYPHS[int'(magnitude % base)], text);
      magnitude = magnitude / base;
    end while (magnitude != 0);
    if (value[31]) begin
      text = $sformatf("%c%s", MINUS_CODE, text);
    end
    return text;
  endfunction

  // Turn a string into owed beats; the final character carries last_char
  function automatic void owe_text(string text);
    char_beat_t beat;
    byte        ch;
    for (int i = 0; i < text.len(); i++) begin
      ch             = text[i];
      beat.char_code = ch[CHAR_W-1:0];
      beat.last_char = (i == text.len() - 1);
      chars_due.push_back(beat);
    end
  endfunction

  function automatic void add_case(logic [RADIX_W-1:0] radix, logic [31:0] value, string text);
    conversion_case_t row;
    row.radix = radix;
    row.value = value;
    row.text  = text;
    conversion_cases.push_back(row);
  endfunction

  // Full-range values most often, with a fair share of short magnitudes of
  // either sign and the corner values around zero and the extremes.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        v = $urandom();
      end
      3: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = ~v + 32'd1;
      end
      4: begin
        v = 32'($urandom_range(0, 40));
        if ($urandom_range(0, 1) == 1) v = ~v + 32'd1;
      end
      5: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h8000_0000;
          4:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
      default: begin
        v = $urandom() >> $urandom_range(16, 28);
      end
    endcase
    return v;
  endfunction

  // Sink side: random backpressure, same odds as the sender
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Scoreboard: every accepted beat must match the oldest owed character
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (chars_due.size() == 0) begin
        $error("beat with nothing owed: char_code %h last_char %b",
               out_ch.char_code, out_ch.last_char);
        errors++;
      end else begin
        oldest = chars_due.pop_front();
        if (out_ch.char_code !== oldest.char_code) begin
          $error("char_code: expected %h, got %h", oldest.char_code, out_ch.char_code);
          errors++;
        end
        if (out_ch.last_char !== oldest.last_char) begin
          $error("last_char: expected %b, got %b", oldest.last_char, out_ch.last_char);
          errors++;
        end
      end
    end
  end

  // Offer one value; owe its text once the beat is taken. valid stays up
  // after acceptance so back-to-back items need no extra edge.
  task automatic send_value(logic [31:0] value, string text);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    if (text == "") text = spell_value(value, radix_shadow);
    owe_text(text);
  endtask

  // Radix changes only with the block idle: stop sending, let every owed
  // character drain, then write.
  task automatic write_radix(logic [RADIX_W-1:0] radix);
    in_ch.valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= radix;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    radix_shadow = radix;
  endtask

  initial begin
    logic [RADIX_W-1:0] phase_radix;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.radix <= RADIX_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first rows run on the reset radix (10), no write yet
    add_case(5'd10, 32'd0,          "0");
    add_case(5'd10, 32'h7FFF_FFFF,  "2147483647");
    add_case(5'd10, 32'h8000_0000,  "-2147483648");
    add_case(5'd10, 32'hFFFF_FFFF,  "-1");
    add_case(5'd10, 32'd12345,      "");
    add_case(5'd10, -32'sd10,       "-10");
    // binary: longest strings, most negative gives the full 33 beats
    add_case(5'd2,  32'h7FFF_FFFF,  "");
    add_case(5'd2,  32'h8000_0000,  "");
    add_case(5'd2,  32'hFFFF_FFFF,  "-1");
    // hex: every letter digit
    add_case(5'd16, 32'h8000_0000,  "-80000000");
    add_case(5'd16, 32'hDEAD_BEEF,  "");
    add_case(5'd16, 32'h7FFF_FFFF,  "7fffffff");
    add_case(5'd16, 32'h00AB_CDEF,  "abcdef");
    // clamped radix codes: 0 and 1 act as 2, 17 and up as 16
    add_case(5'd0,  32'd5,          "101");
    add_case(5'd1,  32'd6,          "110");
    add_case(5'd31, 32'd255,        "ff");
    add_case(5'd17, -32'sd255,      "-ff");
    // odd bases
    add_case(5'd3,  32'd0,          "0");
    add_case(5'd3,  32'h8000_0000,  "");
    add_case(5'd7,  32'd123456789,  "");
    add_case(5'd7,  -32'sd48,       "");

    foreach (conversion_cases[i]) begin
      if (conversion_cases[i].radix != radix_shadow) write_radix(conversion_cases[i].radix);
      send_value(conversion_cases[i].value, conversion_cases[i].text);
    end

    // Random: one radix per phase; phase 3 runs with no idling on either side
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_radix = RADIX_MIN;
        1:       phase_radix = RADIX_MAX;
        2:       phase_radix = RADIX_RESET;
        default: begin
          if ($urandom_range(0, 3) == 0) phase_radix = RADIX_W'($urandom_range(0, 31));
          else phase_radix = RADIX_W'($urandom_range(2, 16));
        end
      endcase
      write_radix(phase_radix);
      idle_pct = (phase == 3) ? 0 : 19;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_value(pick_value(), "");
      end
    end

    in_ch.valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    // catch any stray beat after the last string
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
